@@ design/cbc_pkg.sv @@
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants of the bounding circle block
// widths, store depth and the front-to-back command record
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int MaxPoints = 256;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CountW    = $clog2(MaxPoints + 1);
    localparam int CoordW    = 24;
    localparam int SumW      = CoordW + AddrW;
    localparam int DistW     = 2 * CoordW + 2;
    localparam int RadiusW   = 25;
    localparam int PointW    = 2 * CoordW;
    localparam int QDepth    = 2;

    // one closed set handed from the front part to the back part
    typedef struct packed {
        logic signed [SumW-1:0] sum_x;
        logic signed [SumW-1:0] sum_y;
        logic [CountW-1:0]      count;
    } cbc_job_t;

endpackage

@@ design/cbc_ram.sv @@
// ----------------------------------------------------------------------------
// cbc_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module cbc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/cbc_front.sv @@
// ----------------------------------------------------------------------------
// cbc_front: point intake
// writes points to the store, keeps sums and count, queues a job per set
// ----------------------------------------------------------------------------
module cbc_front import cbc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CoordW-1:0] px,
    input  logic signed [CoordW-1:0] py,
    input  logic                     last,
    output logic                     wr_en,
    output logic [AddrW-1:0]         wr_addr,
    output logic [PointW-1:0]        wr_data,
    output logic                     job_valid,
    output cbc_job_t                 job,
    input  logic                     store_busy
);

    logic [CountW-1:0]      count_reg, count_next;
    logic signed [SumW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic                   acc, room;

    // the back part reads the store, so intake waits until the previous set is done
    assign in_ready = !store_busy && !job_valid;
    assign acc      = in_valid && in_ready;
    assign room     = count_reg < CountW'(MaxPoints);

    assign wr_en   = acc && room;
    assign wr_addr = count_reg[AddrW-1:0];
    assign wr_data = {py, px};

    always_comb
    begin
        count_next = count_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        if (acc)
        begin
            if (room)
            begin
                count_next = count_reg + 1'b1;
                sx_next    = sx_reg + SumW'(px);
                sy_next    = sy_reg + SumW'(py);
            end
            if (last)
            begin
                count_next = '0;
                sx_next    = '0;
                sy_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            job_valid <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            if (acc && last)
            begin
                job_valid <= 1'b1;
            end
            else if (!store_busy)
            begin
                job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && last)
        begin
            job.count <= room ? count_reg + 1'b1 : count_reg;
            job.sum_x <= room ? sx_reg + SumW'(px) : sx_reg;
            job.sum_y <= room ? sy_reg + SumW'(py) : sy_reg;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(MaxPoints))
        else $error("point count beyond store");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !wr_en)
        else $error("store written while read");
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(job_valid) |-> job.count != '0)
        else $error("empty set");
`endif

endmodule

@@ design/cbc_back.sv @@
// ----------------------------------------------------------------------------
// cbc_back: centre, distance pass and root
// serial division, one store entry per cycle, bit-serial square root
// ----------------------------------------------------------------------------
module cbc_back import cbc_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    input  cbc_job_t                  job,
    output logic                      busy,
    output logic [AddrW-1:0]          rd_addr,
    input  logic [PointW-1:0]         rd_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [CoordW-1:0]  cx_out,
    output logic signed [CoordW-1:0]  cy_out,
    output logic [RadiusW-1:0]        r_out
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_SCAN = 6'b000100,
        S_SQ   = 6'b001000,
        S_ROOT = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    localparam int StepW = $clog2(DistW + 1);

    state_t state_reg;
    logic [StepW-1:0] step_reg;
    logic [CountW-1:0] cnt_reg, idx_reg;
    // division: restoring, one quotient bit per cycle on magnitudes
    logic [SumW-1:0] qx_reg, qy_reg, rx_reg, ry_reg;
    logic nx_reg, ny_reg;
    logic signed [CoordW-1:0] cx_reg, cy_reg;
    logic [SumW:0] trx, try_;
    // scan
    logic signed [CoordW:0] dx_reg, dy_reg;
    logic signed [DistW-1:0] sqx, sqy;
    logic dv_reg, sq_reg;
    logic [DistW-1:0] ddx_reg, ddy_reg, best_reg;
    logic pv_reg;
    // root
    logic [DistW-1:0] v_reg, root_reg, bit_reg;

    assign busy    = state_reg != S_IDLE;
    assign rd_addr = idx_reg[AddrW-1:0];
    assign trx     = {rx_reg, qx_reg[SumW-1]};
    assign try_    = {ry_reg, qy_reg[SumW-1]};
    assign out_valid = state_reg == S_OUT;
    assign cx_out  = cx_reg;
    assign cy_out  = cy_reg;
    // full-width signed squares of the differences
    assign sqx     = dx_reg * dx_reg;
    assign sqy     = dy_reg * dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
            pv_reg    <= 1'b0;
            dv_reg    <= 1'b0;
            sq_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= S_DIV;
                        step_reg  <= '0;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == StepW'(SumW - 1))
                    begin
                        state_reg <= S_SCAN;
                        idx_reg   <= '0;
                    end
                end
                S_SCAN:
                begin
                    // pipe: read, difference, squares, compare
                    pv_reg <= idx_reg < cnt_reg;
                    if (idx_reg < cnt_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    dv_reg <= pv_reg;
                    sq_reg <= dv_reg;
                    if (!pv_reg && !dv_reg && !sq_reg && !(idx_reg < cnt_reg))
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_ROOT;
                    step_reg  <= '0;
                end
                S_ROOT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == StepW'(DistW / 2 - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cnt_reg  <= job.count;
                nx_reg   <= job.sum_x[SumW-1];
                ny_reg   <= job.sum_y[SumW-1];
                qx_reg   <= job.sum_x[SumW-1] ? -job.sum_x : job.sum_x;
                qy_reg   <= job.sum_y[SumW-1] ? -job.sum_y : job.sum_y;
                rx_reg   <= '0;
                ry_reg   <= '0;
                best_reg <= '0;
            end
            S_DIV:
            begin
                if (trx >= (SumW + 1)'(cnt_reg))
                begin
                    rx_reg <= SumW'(trx - (SumW + 1)'(cnt_reg));
                    qx_reg <= {qx_reg[SumW-2:0], 1'b1};
                end
                else
                begin
                    rx_reg <= trx[SumW-1:0];
                    qx_reg <= {qx_reg[SumW-2:0], 1'b0};
                end
                if (try_ >= (SumW + 1)'(cnt_reg))
                begin
                    ry_reg <= SumW'(try_ - (SumW + 1)'(cnt_reg));
                    qy_reg <= {qy_reg[SumW-2:0], 1'b1};
                end
                else
                begin
                    ry_reg <= try_[SumW-1:0];
                    qy_reg <= {qy_reg[SumW-2:0], 1'b0};
                end
            end
            S_SCAN:
            begin
                cx_reg <= nx_reg ? CoordW'(-qx_reg) : CoordW'(qx_reg);
                cy_reg <= ny_reg ? CoordW'(-qy_reg) : CoordW'(qy_reg);
                dx_reg <= (CoordW + 1)'($signed(rd_data[CoordW-1:0])) - (CoordW + 1)'(cx_reg);
                dy_reg <= (CoordW + 1)'($signed(rd_data[PointW-1:CoordW])) - (CoordW + 1)'(cy_reg);
                ddx_reg <= sqx;
                ddy_reg <= sqy;
                if (sq_reg && (ddx_reg + ddy_reg > best_reg))
                begin
                    best_reg <= ddx_reg + ddy_reg;
                end
            end
            S_SQ:
            begin
                v_reg    <= best_reg;
                root_reg <= '0;
                bit_reg  <= DistW'(1) << (DistW - 2);
            end
            S_ROOT:
            begin
                if (v_reg >= root_reg + bit_reg)
                begin
                    v_reg    <= v_reg - (root_reg + bit_reg);
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
            end
        endcase
    end

    assign r_out = RadiusW'(root_reg);

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= cnt_reg || state_reg != S_SCAN)
        else $error("scan index beyond set");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_pend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !pv_reg && !dv_reg && !sq_reg)
        else $error("scan pipe not drained");
`endif

endmodule

@@ design/centroid_bounding_circle.sv @@
// ----------------------------------------------------------------------------
// centroid_bounding_circle: centroid and bounding radius of a point set
// points are stored and summed; a closing pass gives centre and radius
// ----------------------------------------------------------------------------
// channel  dir  tdata bits (low first)                 tuser
// s_axis   in   point_x[23:0], point_y[47:24]          tlast = last_point
// m_axis   out  center_x[23:0], center_y[47:24],       -
//               radius[72:48], zero pad to 80
//
// points are taken one per cycle while no set is being closed
// a closing set runs a serial division, then a scan over the store read port,
// then a load step and a bit-serial root
// the result waits in its register until m_axis_tready; intake stalls meanwhile
// reset clears counts and sums; the store needs no clearing
// ----------------------------------------------------------------------------
module centroid_bounding_circle import cbc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // point_x, point_y
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // center_x, center_y, radius, pad
);

    logic                     wr_en, job_valid, busy;
    logic [AddrW-1:0]         wr_addr, rd_addr;
    logic [PointW-1:0]        wr_data, rd_data;
    cbc_job_t                 job;
    logic signed [CoordW-1:0] cx, cy;
    logic [RadiusW-1:0]       r;

    cbc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .px(s_axis_tdata[23:0]), .py(s_axis_tdata[47:24]), .last(s_axis_tlast),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_valid(job_valid), .job(job), .store_busy(busy)
    );

    cbc_ram #(.Width(PointW), .Depth(MaxPoints)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    cbc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job(job), .busy(busy),
        .rd_addr(rd_addr), .rd_data(rd_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cx_out(cx), .cy_out(cy), .r_out(r)
    );

    assign m_axis_tdata = {7'd0, r, cy, cx};

endmodule

@@ tb/sv/centroid_bounding_circle_test.sv @@
// ----------------------------------------------------------------------------
// centroid_bounding_circle_test: self-checking bench of the bounding circle
// drives point sets with random gaps, predicts centre and radius per set
// ----------------------------------------------------------------------------
module centroid_bounding_circle_test import cbc_pkg::*; ();

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               last;
    } point_t;

    typedef struct {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [24:0]        radius;
    } circle_t;

    // directed row: a point, and for obvious sets the typed-in result
    typedef struct {
        point_t  p;
        bit      typed;
        circle_t want;
    } row_t;

    typedef struct {
        int      set_no;
        circle_t want;
    } typed_t;

    localparam logic signed [23:0] CMax = 24'sh7FFFFF;
    localparam logic signed [23:0] CMin = -24'sh800000;
    localparam int WatchdogLimit = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // point_x, point_y
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // center_x, center_y, radius, pad

    // predictor state
    logic signed [23:0] held_x[MaxPoints];
    logic signed [23:0] held_y[MaxPoints];
    int                 held_count = 0;
    longint             total_x = 0;
    longint             total_y = 0;

    circle_t circle_q[$];
    typed_t  typed_q[$];
    point_t  points_q[$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      results_seen = 0;

    centroid_bounding_circle dut (.*);

    always #5 clk = ~clk;

    function automatic longint floor_root(longint v);
        longint r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v) r--;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    // feed one accepted point to the predictor
    function automatic void predict_circle(point_t p);
        longint cx, cy, dx, dy, d, far, root;
        circle_t c;
        if (held_count < MaxPoints) begin
            held_x[held_count] = p.x;
            held_y[held_count] = p.y;
            total_x += p.x;
            total_y += p.y;
            held_count++;
        end
        if (!p.last) return;
        cx = total_x / held_count;
        cy = total_y / held_count;
        far = 0;
        for (int i = 0; i < held_count; i++) begin
            dx = longint'(held_x[i]) - cx;
            dy = longint'(held_y[i]) - cy;
            d = dx * dx + dy * dy;
            if (d > far) far = d;
        end
        root = floor_root(far);
        c.cx = cx[23:0];
        c.cy = cy[23:0];
        c.radius = root[24:0];
        circle_q.push_back(c);
        held_count = 0;
        total_x = 0;
        total_y = 0;
    endfunction

    // result checking and watchdog
    always @(posedge clk) begin
        circle_t want;
        typed_t  typed;
        bit any;
        any = 0;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            any = 1;
            predict_circle('{x: s_axis_tdata[23:0], y: s_axis_tdata[47:24],
                             last: s_axis_tlast});
        end
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            any = 1;
            if (circle_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = circle_q.pop_front();
                if (m_axis_tdata[23:0] !== want.cx || m_axis_tdata[47:24] !== want.cy
                        || m_axis_tdata[72:48] !== want.radius) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected cx %h cy %h r %h, got cx %h cy %h r %h",
                                 want.cx, want.cy, want.radius, m_axis_tdata[23:0],
                                 m_axis_tdata[47:24], m_axis_tdata[72:48]);
                end
            end
            if (typed_q.size() > 0 && typed_q[0].set_no == results_seen) begin
                typed = typed_q.pop_front();
                if (m_axis_tdata[23:0] !== typed.want.cx
                        || m_axis_tdata[47:24] !== typed.want.cy
                        || m_axis_tdata[72:48] !== typed.want.radius) begin
                    errors++;
                    if (errors <= 10)
                        $display("directed: expected cx %h cy %h r %h, got cx %h cy %h r %h",
                                 typed.want.cx, typed.want.cy, typed.want.radius,
                                 m_axis_tdata[23:0], m_axis_tdata[47:24],
                                 m_axis_tdata[72:48]);
                end
            end
            results_seen++;
        end
        idle_cycles = any ? 0 : idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge clk);
            phase++;
            if (phase < 300) m_axis_tready <= 1'b1;
            else if (phase < 800) m_axis_tready <= (phase % 7) != 3;
            else if (phase < 1400) m_axis_tready <= ($urandom_range(0, 3) != 0);
            else m_axis_tready <= ($urandom_range(0, 1) != 0);
            if (phase >= 2000) phase = 0;
        end
    end

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CMax;
            1: return CMin;
            2: return 24'($urandom_range(0, 2047)) - 24'sd1024;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic add_set(int n);
        for (int i = 0; i < n; i++)
            points_q.push_back('{x: rand_coord(), y: rand_coord(), last: i == n - 1});
    endtask

    task automatic send_point(point_t p);
        s_axis_tdata  <= {p.y, p.x};
        s_axis_tlast  <= p.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // directed rows; single-point sets carry their obvious result
    row_t directed_rows[12] = '{
        '{p: '{x: 24'sd0,  y: 24'sd0,  last: 1'b1}, typed: 1'b1,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}},
        '{p: '{x: CMax,    y: CMin,    last: 1'b1}, typed: 1'b1,
          want: '{cx: CMax, cy: CMin, radius: 25'd0}},
        '{p: '{x: CMin,    y: CMax,    last: 1'b1}, typed: 1'b1,
          want: '{cx: CMin, cy: CMax, radius: 25'd0}},
        '{p: '{x: CMax,    y: CMax,    last: 1'b0}, typed: 1'b0,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}},
        '{p: '{x: CMin,    y: CMin,    last: 1'b1}, typed: 1'b0,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}},
        '{p: '{x: 24'sd3,  y: -24'sd3, last: 1'b0}, typed: 1'b0,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}},
        '{p: '{x: 24'sd0,  y: 24'sd0,  last: 1'b1}, typed: 1'b0,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}},
        '{p: '{x: -24'sd5, y: 24'sd7,  last: 1'b0}, typed: 1'b0,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}},
        '{p: '{x: 24'sd0,  y: 24'sd0,  last: 1'b0}, typed: 1'b0,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}},
        '{p: '{x: 24'sd1,  y: -24'sd1, last: 1'b1}, typed: 1'b0,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}},
        '{p: '{x: CMax,    y: CMin,    last: 1'b0}, typed: 1'b0,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}},
        '{p: '{x: CMin,    y: CMax,    last: 1'b1}, typed: 1'b0,
          want: '{cx: 24'sd0, cy: 24'sd0, radius: 25'd0}}
    };

    initial begin
        int burst;
        int sets_queued;
        bit paused;
        point_t p;
        sets_queued = 0;
        paused = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            points_q.push_back(directed_rows[i].p);
            if (directed_rows[i].p.last) begin
                if (directed_rows[i].typed)
                    typed_q.push_back('{set_no: sets_queued, want: directed_rows[i].want});
                sets_queued++;
            end
        end
        // full store: extra points are dropped, the last still closes
        for (int i = 0; i < MaxPoints + 3; i++)
            points_q.push_back('{x: rand_coord(), y: rand_coord(),
                                 last: i == MaxPoints + 2});
        while (points_q.size() < 500) begin
            if ($urandom_range(0, 9) == 0) add_set($urandom_range(1, 40));
            else add_set($urandom_range(1, 6));
        end

        while (points_q.size() > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && points_q.size() > 0) begin
                p = points_q.pop_front();
                send_point(p);
                burst--;
            end
            s_axis_tvalid <= 1'b0;
            if (!paused && points_q.size() <= 250) begin
                paused = 1;
                while (circle_q.size() > 0) @(negedge clk);
            end
            else
                repeat ($urandom_range(0, 5)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (circle_q.size() > 0) @(negedge clk);
        repeat (400) @(negedge clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
